@@ src/bve_pkg.sv @@
// ----------------------------------------------------------------------------
// bve_pkg: shared definitions for the burst velocity estimator
// Holds defaults, register indexes, the back-end state type and the
// signal groups that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package bve_pkg;

    // Default saturation limit of the per-burst sample count.
    localparam int MAX_BURST_DEF = 8192;

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic CFG_NOISE_FLOOR    = 1'b0;
    localparam logic CFG_SEND_THRESHOLD = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] NOISE_FLOOR_RST    = 8'd1;
    localparam logic [6:0] SEND_THRESHOLD_RST = 7'd2;

    // Velocity limits of the mapping.
    localparam logic [6:0] VEL_MIN = 7'd1;
    localparam logic [6:0] VEL_MAX = 7'd127;

    // Configuration seen by the front end and the back end.
    typedef struct packed {
        logic [7:0] noise_floor;
        logic [6:0] send_threshold;
    } bve_cfg_t;

    // Queue status seen by the writer and the reader.
    typedef struct packed {
        logic full;
        logic empty;
    } bve_qstat_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CMP,
        ST_DIV,
        ST_OUT
    } bve_state_t;

endpackage

@@ src/bve_front.sv @@
// ----------------------------------------------------------------------------
// bve_front: burst accumulator
// Filters samples against the noise floor and keeps the running sum, count
// and peak of the current burst; hands the totals on at the burst's end.
// ----------------------------------------------------------------------------
module bve_front #(
    parameter int MAX_BURST = bve_pkg::MAX_BURST_DEF,
    localparam int CW = $clog2(MAX_BURST + 1),
    localparam int SW = $clog2(MAX_BURST * 255 + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bve_pkg::bve_cfg_t cfg,
    input  logic              accept,
    input  logic [7:0]        sample,
    input  logic              last_sample,
    output logic              push,
    output logic [SW-1:0]     burst_sum,
    output logic [CW-1:0]     burst_count,
    output logic [7:0]        burst_peak
);

    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    peak_reg, peak_next;
    logic          counted;

    // Totals including the request now being accepted.
    always_comb
    begin
        counted     = sample > cfg.noise_floor;
        burst_sum   = sum_reg;
        burst_count = count_reg;
        burst_peak  = peak_reg;
        if (counted)
        begin
            if (sample > peak_reg)
            begin
                burst_peak = sample;
            end
            if (count_reg < CW'(MAX_BURST))
            begin
                burst_sum   = sum_reg + SW'(sample);
                burst_count = count_reg + CW'(1);
            end
        end
        push = accept && last_sample;
    end

    // Accumulators clear once a burst has been handed on.
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        peak_next  = peak_reg;
        if (accept)
        begin
            if (last_sample)
            begin
                sum_next   = '0;
                count_next = '0;
                peak_next  = '0;
            end
            else
            begin
                sum_next   = burst_sum;
                count_next = burst_count;
                peak_next  = burst_peak;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            peak_reg  <= peak_next;
        end
    end

endmodule

@@ src/bve_queue.sv @@
// ----------------------------------------------------------------------------
// bve_queue: burst totals queue
// A short first-in first-out queue that lets the accumulator start a new
// burst while the velocity unit is still working on an earlier one.
// ----------------------------------------------------------------------------
module bve_queue #(
    parameter int WIDTH = 8,
    localparam int DEPTH = bve_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    rd_data,
    output bve_pkg::bve_qstat_t stat
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - NW'(1);
        end
        stat.full  = fill_reg == NW'(DEPTH);
        stat.empty = fill_reg == '0;
        rd_data    = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue read while empty");
    a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> fill_reg == $past(fill_reg) + NW'(1))
        else $error("queue fill count lost a write");
`endif

endmodule

@@ src/bve_back.sv @@
// ----------------------------------------------------------------------------
// bve_back: velocity unit
// Turns one burst's sum, count and peak into a velocity with exact rational
// arithmetic: multiply, compare against the limits, then a restoring
// division of seven quotient bits, one bit per cycle.
// ----------------------------------------------------------------------------
module bve_back #(
    parameter int MAX_BURST = bve_pkg::MAX_BURST_DEF,
    localparam int CW = $clog2(MAX_BURST + 1),
    localparam int SW = $clog2(MAX_BURST * 255 + 1),
    localparam int PW = CW + 8,
    localparam int XW = $clog2(26100 * MAX_BURST + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bve_pkg::bve_cfg_t   cfg,
    input  bve_pkg::bve_qstat_t qstat,
    input  logic [SW-1:0]       q_sum,
    input  logic [CW-1:0]       q_count,
    input  logic [7:0]          q_peak,
    output logic                pop,
    output logic                done,
    output logic [6:0]          velocity
);

    bve_pkg::bve_state_t state_reg, state_next;

    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] c_reg, c_next;
    logic [7:0]    peak_reg, peak_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [XW-1:0] d_reg, d_next;
    logic [XW-1:0] n_reg, n_next;
    logic [XW-1:0] a_reg, a_next;
    logic [XW-1:0] b_reg, b_next;
    logic [6:0]    q_reg, q_next;
    logic [2:0]    step_reg, step_next;
    logic [6:0]    vel_reg, vel_next;
    logic          done_reg, done_next;
    logic [6:0]    velocity_reg, velocity_next;
    logic [6:0]    q_bit;

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        c_next        = c_reg;
        peak_next     = peak_reg;
        prod_next     = prod_reg;
        d_next        = d_reg;
        n_next        = n_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        q_next        = q_reg;
        step_next     = step_reg;
        vel_next      = vel_reg;
        done_next     = 1'b0;
        velocity_next = velocity_reg;
        pop           = 1'b0;
        q_bit         = q_reg;
        case (state_reg)
            bve_pkg::ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop       = 1'b1;
                    sum_next  = q_sum;
                    c_next    = (q_count == '0) ? CW'(1) : q_count;
                    peak_next = q_peak;
                    state_next = bve_pkg::ST_MUL;
                end
            end
            bve_pkg::ST_MUL:
            begin
                // Peak times count, and the denominator D = 10c.
                prod_next  = PW'(peak_reg) * PW'(c_reg);
                d_next     = XW'(c_reg) * XW'(10);
                state_next = bve_pkg::ST_SUM;
            end
            bve_pkg::ST_SUM:
            begin
                // Numerator N = sum + 5 * peak * c.
                n_next     = XW'(sum_reg) + XW'(prod_reg) * XW'(5);
                state_next = bve_pkg::ST_CMP;
            end
            bve_pkg::ST_CMP:
            begin
                // Clamp at both ends, otherwise set up 29(N - 20D) / 25D.
                if (n_reg <= d_reg * XW'(20))
                begin
                    vel_next   = bve_pkg::VEL_MIN;
                    state_next = bve_pkg::ST_OUT;
                end
                else if (n_reg >= d_reg * XW'(110))
                begin
                    vel_next   = bve_pkg::VEL_MAX;
                    state_next = bve_pkg::ST_OUT;
                end
                else
                begin
                    a_next     = (n_reg - d_reg * XW'(20)) * XW'(29);
                    b_next     = d_reg * XW'(1600);
                    q_next     = '0;
                    step_next  = '0;
                    state_next = bve_pkg::ST_DIV;
                end
            end
            bve_pkg::ST_DIV:
            begin
                // One restoring division step; the divisor walks down by one bit.
                if (a_reg >= b_reg)
                begin
                    a_next = a_reg - b_reg;
                    q_bit  = {q_reg[5:0], 1'b1};
                end
                else
                begin
                    q_bit = {q_reg[5:0], 1'b0};
                end
                q_next    = q_bit;
                b_next    = b_reg >> 1;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    vel_next   = q_bit + 7'd1;
                    state_next = bve_pkg::ST_OUT;
                end
            end
            bve_pkg::ST_OUT:
            begin
                // Send only velocities above the threshold.
                done_next     = vel_reg > cfg.send_threshold;
                velocity_next = vel_reg;
                state_next    = bve_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bve_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bve_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        c_reg        <= c_next;
        peak_reg     <= peak_next;
        prod_reg     <= prod_next;
        d_reg        <= d_next;
        n_reg        <= n_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        q_reg        <= q_next;
        step_reg     <= step_next;
        vel_reg      <= vel_next;
        velocity_reg <= velocity_next;
    end

    assign done     = done_reg;
    assign velocity = velocity_reg;

`ifndef NO_ASSERTIONS
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");
    a_above_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (velocity > cfg.send_threshold) && (velocity != 7'd0))
        else $error("result sent at or below the threshold");
    a_strobe_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == bve_pkg::ST_OUT)
        else $error("result strobe outside the output step");
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == bve_pkg::ST_IDLE)
        else $error("queue read while the velocity unit is busy");
`endif

endmodule

@@ src/burst_velocity_estimator_top.sv @@
// ----------------------------------------------------------------------------
// burst_velocity_estimator_top: burst velocity estimator
// Accumulates bursts of ADC samples and reports a hit velocity for each burst
// whose velocity is above the send threshold.
//   Channel   Ports                              Handshake
//   -------   --------------------------------   ---------------------------
//   request   start, busy, sample, last_sample   taken when start && !busy
//   result    done, velocity                     one-cycle strobe, no stall
//   config    cfg_we, cfg_addr, cfg_wdata        written when cfg_we is high
//
// One sample is taken every cycle while busy is low. The velocity unit takes
// each queued burst in turn through its multiply, sum and compare steps, then
// the seven-step divider for values that are not clamped, and an output step
// that registers the result strobe.
// Busy rises only while the queue holds two finished bursts.
// Reset clears the accumulators and queue at once; no clearing pass.
// The receiver cannot stall; the result strobe is high for one cycle only.
// ----------------------------------------------------------------------------
module burst_velocity_estimator_top #(
    parameter int MAX_BURST = bve_pkg::MAX_BURST_DEF,
    localparam int CW = $clog2(MAX_BURST + 1),
    localparam int SW = $clog2(MAX_BURST * 255 + 1),
    localparam int EW = SW + CW + 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] sample,
    input  logic       last_sample,
    output logic       done,
    output logic [6:0] velocity,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_wdata
);

    bve_pkg::bve_cfg_t   cfg;
    bve_pkg::bve_qstat_t qstat;

    logic [7:0]    noise_floor_reg, noise_floor_next;
    logic [6:0]    send_threshold_reg, send_threshold_next;
    logic          accept;
    logic          push;
    logic          pop;
    logic [SW-1:0] f_sum;
    logic [CW-1:0] f_count;
    logic [7:0]    f_peak;
    logic [EW-1:0] q_wr_data;
    logic [EW-1:0] q_rd_data;

    // Configuration register writes.
    always_comb
    begin
        noise_floor_next    = noise_floor_reg;
        send_threshold_next = send_threshold_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                bve_pkg::CFG_NOISE_FLOOR:    noise_floor_next    = cfg_wdata;
                bve_pkg::CFG_SEND_THRESHOLD: send_threshold_next = cfg_wdata[6:0];
                default:                     noise_floor_next    = noise_floor_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_floor_reg    <= bve_pkg::NOISE_FLOOR_RST;
            send_threshold_reg <= bve_pkg::SEND_THRESHOLD_RST;
        end
        else
        begin
            noise_floor_reg    <= noise_floor_next;
            send_threshold_reg <= send_threshold_next;
        end
    end

    // Request acceptance.
    always_comb
    begin
        cfg.noise_floor    = noise_floor_reg;
        cfg.send_threshold = send_threshold_reg;
        busy               = qstat.full;
        accept             = start && !busy;
        q_wr_data          = {f_sum, f_count, f_peak};
    end

    bve_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .sample      (sample),
        .last_sample (last_sample),
        .push        (push),
        .burst_sum   (f_sum),
        .burst_count (f_count),
        .burst_peak  (f_peak)
    );

    bve_queue #(
        .WIDTH (EW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (q_wr_data),
        .pop     (pop),
        .rd_data (q_rd_data),
        .stat    (qstat)
    );

    bve_back #(
        .MAX_BURST (MAX_BURST)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .qstat    (qstat),
        .q_sum    (q_rd_data[EW-1 -: SW]),
        .q_count  (q_rd_data[8 +: CW]),
        .q_peak   (q_rd_data[7:0]),
        .pop      (pop),
        .done     (done),
        .velocity (velocity)
    );

endmodule

@@ sim/burst_velocity_estimator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_velocity_estimator_top_tb: self-checking bench for the estimator
// Streams bursts of ADC samples under several noise floor and send threshold
// settings, predicts each emitted hit velocity with exact integer arithmetic,
// and compares every strobed result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module burst_velocity_estimator_top_tb;

    // A short burst limit so that saturation is reached within a few bursts.
    localparam int BURST_LIMIT = 64;
    // Cycles to wait after the last prediction; covers a full queue of bursts
    // behind a divide, including bursts that send nothing.
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_GUARD = 5000;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 90;

    // Tracks the per-burst accumulators and the velocities still owed.
    class hit_velocity_board;
        logic [7:0]  floor_reg;
        logic [6:0]  thresh_reg;
        logic [20:0] sum_acc;
        logic [13:0] count_acc;
        logic [7:0]  peak_acc;
        logic [6:0]  owed_velocity[$];
        int          failures;

        function new();
            floor_reg  = bve_pkg::NOISE_FLOOR_RST;
            thresh_reg = bve_pkg::SEND_THRESHOLD_RST;
            sum_acc    = '0;
            count_acc  = '0;
            peak_acc   = '0;
            failures   = 0;
        endfunction

        function void write_reg(logic addr, logic [7:0] data);
            if (addr == bve_pkg::CFG_NOISE_FLOOR)
            begin
                floor_reg = data;
            end
            else
            begin
                thresh_reg = data[6:0];
            end
        endfunction

        // Exact form of x = avg/10 + peak/2 mapped onto the velocity curve.
        function logic [6:0] map_velocity();
            longint unsigned c;
            longint unsigned num;
            longint unsigned den;
            c   = (count_acc != 0) ? longint'(count_acc) : 1;
            num = longint'(sum_acc) + 5 * longint'(peak_acc) * c;
            den = 10 * c;
            if (num <= 20 * den)
            begin
                return bve_pkg::VEL_MIN;
            end
            if (num >= 110 * den)
            begin
                return bve_pkg::VEL_MAX;
            end
            return 7'(1 + (29 * (num - 20 * den)) / (25 * den));
        endfunction

        function void note_request(logic [7:0] s, logic last);
            logic [6:0] vel;
            if (s > floor_reg)
            begin
                if (s > peak_acc)
                begin
                    peak_acc = s;
                end
                // Sum and count hold once the burst reaches its limit.
                if (count_acc < BURST_LIMIT)
                begin
                    sum_acc   = sum_acc + s;
                    count_acc = count_acc + 1;
                end
            end
            if (last)
            begin
                vel = map_velocity();
                if (vel > thresh_reg)
                begin
                    owed_velocity.push_back(vel);
                end
                sum_acc   = '0;
                count_acc = '0;
                peak_acc  = '0;
            end
        endfunction

        function void check_velocity(logic [6:0] actual);
            logic [6:0] want;
            if (owed_velocity.size() == 0)
            begin
                $error("velocity: no result expected, got %0d", actual);
                failures++;
                return;
            end
            want = owed_velocity.pop_front();
            if (actual !== want)
            begin
                $error("velocity: expected %0d, got %0d", want, actual);
                failures++;
            end
        endfunction

        function int pending();
            return owed_velocity.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [7:0] sample;
    logic       last_sample;
    logic       done;
    logic [6:0] velocity;
    logic       cfg_we;
    logic       cfg_addr;
    logic [7:0] cfg_wdata;

    hit_velocity_board board;
    logic              steady;
    int                items_sent;

    burst_velocity_estimator_top #(
        .MAX_BURST (BURST_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .sample      (sample),
        .last_sample (last_sample),
        .done        (done),
        .velocity    (velocity),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Observe results, accepted requests and register writes at each edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                board.check_velocity(velocity);
            end
            if (start && !busy)
            begin
                board.note_request(sample, last_sample);
            end
            if (cfg_we)
            begin
                board.write_reg(cfg_addr, cfg_wdata);
            end
        end
    end

    // Offer one request, with an optional idle gap first; ends at a falling edge.
    task automatic send_request(input logic [7:0] s, input logic last);
        int gap;
        if (!steady && $urandom_range(99) < 36)
        begin
            start = 1'b0;
            gap = $urandom_range(5, 1);
            repeat (gap) @(negedge clk);
        end
        start       = 1'b1;
        sample      = s;
        last_sample = last;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic addr, input logic [7:0] data);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Hold off requests until every predicted velocity has come out.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        start = 1'b0;
        while (board.pending() != 0 && guard < DRAIN_GUARD)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random sample, biased around the noise floor and the extremes.
    function automatic logic [7:0] pick_sample(input logic [7:0] floor_v);
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            return 8'($urandom_range(int'(floor_v), 0));
        end
        if (r < 22)
        begin
            return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
        end
        if (floor_v == 8'd255)
        begin
            return 8'($urandom_range(255, 0));
        end
        return 8'($urandom_range(255, int'(floor_v) + 1));
    endfunction

    initial
    begin
        int         len;
        int         target;
        logic [7:0] floor_v;
        logic [6:0] thresh_v;
        logic [7:0] floor_set[RANDOM_PHASES];
        logic [6:0] thresh_set[RANDOM_PHASES];

        board       = new();
        steady      = 1'b0;
        items_sent  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        sample      = '0;
        last_sample = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = bve_pkg::CFG_NOISE_FLOOR;
        cfg_wdata   = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed bursts under the reset settings.
        send_request(8'd255, 1'b0);
        send_request(8'd255, 1'b1);
        send_request(8'd1, 1'b1);
        send_request(8'd2, 1'b0);
        send_request(8'd0, 1'b0);
        send_request(8'd128, 1'b1);

        // Lowest floor and threshold: empty bursts and small velocities.
        wait_for_results();
        write_reg(bve_pkg::CFG_NOISE_FLOOR, 8'd0);
        write_reg(bve_pkg::CFG_SEND_THRESHOLD, 8'd0);
        send_request(8'd0, 1'b1);
        send_request(8'd1, 1'b1);
        send_request(8'd200, 1'b0);
        send_request(8'd0, 1'b1);
        send_request(8'd30, 1'b0);
        send_request(8'd60, 1'b0);
        send_request(8'd45, 1'b1);
        send_request(8'd40, 1'b1);

        // Highest floor and threshold: nothing may come out.
        wait_for_results();
        write_reg(bve_pkg::CFG_NOISE_FLOOR, 8'd255);
        write_reg(bve_pkg::CFG_SEND_THRESHOLD, 8'd127);
        send_request(8'd255, 1'b0);
        send_request(8'd128, 1'b1);

        // Threshold write with the unused top bit set.
        wait_for_results();
        write_reg(bve_pkg::CFG_NOISE_FLOOR, 8'd100);
        write_reg(bve_pkg::CFG_SEND_THRESHOLD, {1'b1, 7'd64});
        send_request(8'd220, 1'b0);
        send_request(8'd90, 1'b0);
        send_request(8'd150, 1'b1);

        // Random phases, extremes of the settings first.
        floor_set[0]  = 8'd0;
        thresh_set[0] = 7'd0;
        floor_set[1]  = 8'd255;
        thresh_set[1] = 7'd0;
        floor_set[2]  = 8'd0;
        thresh_set[2] = 7'd127;
        for (int p = 3; p < RANDOM_PHASES; p++)
        begin
            floor_set[p]  = 8'($urandom_range(120, 0));
            thresh_set[p] = 7'($urandom_range(60, 0));
        end
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_for_results();
            floor_v  = floor_set[p];
            thresh_v = thresh_set[p];
            write_reg(bve_pkg::CFG_NOISE_FLOOR, floor_v);
            write_reg(bve_pkg::CFG_SEND_THRESHOLD, {1'($urandom_range(1)), thresh_v});
            // One phase runs back to back with no idle cycles.
            steady = (p == 3);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                len = ($urandom_range(99) < 80) ? $urandom_range(8, 1)
                                                : $urandom_range(40, 9);
                for (int k = 1; k <= len; k++)
                begin
                    send_request(pick_sample(floor_v), k == len);
                end
            end
        end
        steady = 1'b0;

        // Bursts long enough to saturate sum and count; the peak still moves.
        wait_for_results();
        write_reg(bve_pkg::CFG_NOISE_FLOOR, 8'd3);
        write_reg(bve_pkg::CFG_SEND_THRESHOLD, 8'd0);
        for (int b = 0; b < 2; b++)
        begin
            len = BURST_LIMIT + $urandom_range(20, 4);
            for (int k = 1; k <= len; k++)
            begin
                if (k > len - 30)
                begin
                    send_request(8'($urandom_range(255, 100)), k == len);
                end
                else
                begin
                    send_request(8'($urandom_range(30, 0)), 1'b0);
                end
            end
        end

        wait_for_results();
        if (board.pending() != 0)
        begin
            $error("velocity: %0d expected results never arrived", board.pending());
            board.failures++;
        end
        if (board.failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
